@@ hw/rtl/tun_pkg.sv @@
// Shared types and constants for the triangle unit normal block.
// Used by tun_front, tun_cell and triangle_unit_normal_unit.
`default_nettype none
package tun_pkg;
    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int OUT_BITS         = 16;
    // Edge, cross product, magnitude, square and length-squared widths.
    localparam int EW  = COORD_BITS + 1;
    localparam int CW  = 2 * EW + 1;
    localparam int MW  = 2 * EW;
    localparam int SQ  = 2 * MW;
    localparam int LW  = SQ + 2;
    localparam int QW  = NORMAL_FRAC_BITS + 1;
    localparam int PW  = LW + 2 * NORMAL_FRAC_BITS + 3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] first_z;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
        logic signed [COORD_BITS-1:0] second_z;
        logic signed [COORD_BITS-1:0] third_x;
        logic signed [COORD_BITS-1:0] third_y;
        logic signed [COORD_BITS-1:0] third_z;
    } t_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] normal_x;
        logic signed [OUT_BITS-1:0] normal_y;
        logic signed [OUT_BITS-1:0] normal_z;
        logic                       degenerate;
    } t_out;

    // One component's running square-root-division state.
    typedef struct packed {
        logic          neg;
        logic [PW-1:0] rhs;
        logic [QW-1:0] q;
        logic [PW-1:0] p;
        logic [PW-1:0] r;
    } t_lane;

    // Token handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic              degen;
        logic [LW-1:0]     len;
        t_lane [2:0]       lane;
    } t_tok;
endpackage
`default_nettype wire

@@ hw/rtl/tun_front.sv @@
// Front pipeline: edges, cross product, squares and length squared.
// Depends on tun_pkg.
`default_nettype none
module tun_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_adv,
    input  wire logic         i_valid,
    input  wire tun_pkg::t_in i_data,
    output tun_pkg::t_tok     o_tok
);
    localparam int EW = tun_pkg::EW;
    localparam int CW = tun_pkg::CW;
    localparam int MW = tun_pkg::MW;
    localparam int SQ = tun_pkg::SQ;
    localparam int LW = tun_pkg::LW;
    localparam int PW = tun_pkg::PW;
    localparam int F  = tun_pkg::NORMAL_FRAC_BITS;

    logic [3:0] r_v;
    logic signed [EW-1:0] r_a [3];
    logic signed [EW-1:0] r_b [3];
    logic signed [2*EW-1:0] r_p [6];
    logic signed [CW-1:0] r_c [3];
    logic [2:0] r_neg;
    logic [SQ-1:0] r_sq [3];
    tun_pkg::t_tok r_tok;

    logic signed [EW-1:0] n_a [3];
    logic signed [EW-1:0] n_b [3];
    logic [MW-1:0] n_mag [3];
    logic [LW-1:0] n_len;

    // Edge vectors from vertex two.
    always_comb begin
        n_a[0] = EW'(i_data.third_x) - EW'(i_data.second_x);
        n_a[1] = EW'(i_data.third_y) - EW'(i_data.second_y);
        n_a[2] = EW'(i_data.third_z) - EW'(i_data.second_z);
        n_b[0] = EW'(i_data.first_x) - EW'(i_data.second_x);
        n_b[1] = EW'(i_data.first_y) - EW'(i_data.second_y);
        n_b[2] = EW'(i_data.first_z) - EW'(i_data.second_z);
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = r_c[k][CW-1] ? MW'(-r_c[k]) : MW'(r_c[k]);
        end
        n_len = LW'(r_sq[0]) + LW'(r_sq[1]) + LW'(r_sq[2]);
    end

    // Valid tracking through the first four front stages; the fifth rides in the token.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // Payload stages and the token's valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok.valid <= r_v[3];
        end
        if (i_adv) begin
            r_a <= n_a;
            r_b <= n_b;
            r_p[0] <= r_a[1] * r_b[2];
            r_p[1] <= r_a[2] * r_b[1];
            r_p[2] <= r_a[2] * r_b[0];
            r_p[3] <= r_a[0] * r_b[2];
            r_p[4] <= r_a[0] * r_b[1];
            r_p[5] <= r_a[1] * r_b[0];
            r_c[0] <= CW'(r_p[0]) - CW'(r_p[1]);
            r_c[1] <= CW'(r_p[2]) - CW'(r_p[3]);
            r_c[2] <= CW'(r_p[4]) - CW'(r_p[5]);
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= r_c[k][CW-1];
                r_sq[k]  <= n_mag[k] * n_mag[k];
                r_tok.lane[k].neg <= r_neg[k];
                r_tok.lane[k].rhs <= PW'(r_sq[k]) << (2 * F);
                r_tok.lane[k].q   <= '0;
                r_tok.lane[k].p   <= '0;
                r_tok.lane[k].r   <= '0;
            end
            r_tok.len   <= n_len;
            r_tok.degen <= (n_len == '0);
        end
    end

    assign o_tok = r_tok;
endmodule
`default_nettype wire

@@ hw/rtl/tun_cell.sv @@
// One quotient-bit cell: decides bit B of all three normal components.
// Depends on tun_pkg.
`default_nettype none
module tun_cell #(
    parameter int B = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire tun_pkg::t_tok i_tok,
    output tun_pkg::t_tok      o_tok
);
    localparam int PW = tun_pkg::PW;
    localparam int QW = tun_pkg::QW;

    tun_pkg::t_tok r_tok;
    tun_pkg::t_tok n_tok;
    logic [PW-1:0] n_try [3];

    // Trial bit: (q + 2^B)^2 * L = q^2 L + 2^(B+1) q L + 2^(2B) L.
    always_comb begin
        n_tok = i_tok;
        for (int k = 0; k < 3; k++) begin
            n_try[k] = i_tok.lane[k].p + (i_tok.lane[k].r << (B + 1))
                     + (PW'(i_tok.len) << (2 * B));
            if (n_try[k] <= i_tok.lane[k].rhs) begin
                n_tok.lane[k].q = i_tok.lane[k].q | (QW'(1) << B);
                n_tok.lane[k].p = n_try[k];
                n_tok.lane[k].r = i_tok.lane[k].r + (PW'(i_tok.len) << B);
            end
        end
    end

    // Token register: the valid flag is reset, the payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok.valid <= i_tok.valid;
        end
        if (i_adv) begin
            r_tok.degen <= n_tok.degen;
            r_tok.len   <= n_tok.len;
            r_tok.lane  <= n_tok.lane;
        end
    end

    assign o_tok = r_tok;
endmodule
`default_nettype wire

@@ hw/rtl/triangle_unit_normal_unit.sv @@
// Top level of the triangle unit normal block: front pipeline, cell chain, output register.
// Depends on tun_pkg, tun_front and tun_cell.
// Throughput: one transaction per cycle; the whole pipeline holds while the result is stalled.
// The five-stage front, one cell per quotient bit and the output register set the latency.
// Reset clears all valid flags; payload registers are not reset.
`default_nettype none
module triangle_unit_normal_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire tun_pkg::t_in i_data,
    output logic              o_valid,
    input  wire logic         i_stall,
    output tun_pkg::t_out     o_data
);
    localparam int F  = tun_pkg::NORMAL_FRAC_BITS;
    localparam int OB = tun_pkg::OUT_BITS;

    logic w_adv;
    tun_pkg::t_tok w_chain [F+2];
    logic r_out_valid;
    tun_pkg::t_out r_out;
    tun_pkg::t_out n_out;

    // Whole pipeline moves unless a held result is stalled.
    assign o_stall = r_out_valid & i_stall;
    assign w_adv   = ~o_stall;

    tun_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_tok   (w_chain[0])
    );

    // One cell per quotient bit, most significant first.
    for (genvar g = 0; g <= F; g++) begin : g_cell
        tun_cell #(.B(F - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_chain[g]),
            .o_tok   (w_chain[g+1])
        );
    end

    // Apply signs and the degenerate case.
    always_comb begin
        n_out.degenerate = w_chain[F+1].degen;
        n_out.normal_x = w_chain[F+1].lane[0].neg ? -OB'(w_chain[F+1].lane[0].q)
                                                 : OB'(w_chain[F+1].lane[0].q);
        n_out.normal_y = w_chain[F+1].lane[1].neg ? -OB'(w_chain[F+1].lane[1].q)
                                                 : OB'(w_chain[F+1].lane[1].q);
        n_out.normal_z = w_chain[F+1].lane[2].neg ? -OB'(w_chain[F+1].lane[2].q)
                                                 : OB'(w_chain[F+1].lane[2].q);
        if (w_chain[F+1].degen) begin
            n_out.normal_x = '0;
            n_out.normal_y = '0;
            n_out.normal_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_chain[F+1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // A degenerate result carries a zero normal.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.degenerate) |->
        (o_data.normal_x == '0 && o_data.normal_y == '0 && o_data.normal_z == '0))
        else $error("degenerate result with nonzero normal");

    // A stall on the result freezes the pipeline toward the input.
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("held result did not stall the input");

    // A result that was stalled is still presented in the next cycle.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

    // No result appears right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule
`default_nettype wire
